// File: rtl/imsh_pkg.sv
// Shared types and constants of the 3x3 sharpening filter.
`timescale 1ns / 1ps

package imsh_pkg;

	localparam int DEF_MAX_WIDTH = 1024;

	localparam int CH_W       = 8;
	localparam int PX_W       = 3 * CH_W;
	localparam int FW_W       = 11;
	localparam int FH_W       = 16;
	localparam int ROW_W      = FH_W;
	localparam int OROW_W     = FH_W + 1;
	localparam int SUM_W      = 12;
	localparam int RECIP_W    = 13;
	localparam int PROD_W     = SUM_W + RECIP_W;
	localparam int MEAN_SHIFT = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// floor(x / 9) == (x * 7282) >> 16 for every 9-pixel channel sum
	localparam logic [RECIP_W-1:0] MEAN_RECIP = 13'd7282;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// where a result pixel comes from
	localparam logic [1:0] MODE_PASS  = 2'd0; // window center, unchanged
	localparam logic [1:0] MODE_SHARP = 2'd1; // window center, sharpened
	localparam logic [1:0] MODE_MEM   = 2'd2; // row above, straight from memory

	typedef struct packed {
		logic            operation;
		logic [CH_W-1:0] red_in;
		logic [CH_W-1:0] green_in;
		logic [CH_W-1:0] blue_in;
	} in_beat_t;

	typedef struct packed {
		logic [CH_W-1:0] red_out;
		logic [CH_W-1:0] green_out;
		logic [CH_W-1:0] blue_out;
		logic            frame_last;
	} out_beat_t;

	typedef struct packed {
		logic       pixel;
		logic       emit;
		logic       last;
		logic [1:0] mode;
	} stage_ctl_t;

endpackage

// File: rtl/image_sharpen_3x3.sv
// Top level of the 3x3 unsharp-mask sharpener for raster RGB streams.
`timescale 1ns / 1ps

// image_sharpen_3x3 sharpens an RGB frame streamed in raster order. Each
// interior pixel channel gets |pixel - floor(3x3 mean)| added and is clipped
// at 255; border pixels pass unchanged. A result leaves one line plus one
// pixel after its input, so once the last pixel of a frame is in, send drain
// beats (operation = 1) to release the remaining results; a drain with
// nothing pending and a pixel sent while results are still pending are
// consumed and produce nothing. frame_last marks the final result of a frame.
// Set frame_width and frame_height only between frames while the block is
// idle. Throughput is one beat per clock, pixels and drains alike, while
// no blocked output beat stalls the input. A released result passes stages
// 1 to 3 and then the output register. The rate is set by the row memory
// (MAX_WIDTH words holding the two rows above, one read port and one write
// port): every beat does at most one read and every pixel one write-back to
// it, and a write that lands on the address read in the same clock is
// forwarded. The memory needs no clearing pass after reset.

module image_sharpen_3x3
	import imsh_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_beat_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_beat_t             out_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = CW + 1;
	localparam logic [WW-1:0] MAX_W = WW'(MAX_WIDTH);

	// ---------------------------------------------------------------
	// configuration
	// ---------------------------------------------------------------
	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
				default: ;
			endcase
		end
	end

	// zero width acts as one, oversize width is clipped to the row memory
	logic [WW-1:0]     w_eff;
	logic [FH_W-1:0]   h_eff;
	logic [OROW_W-1:0] h_ext;

	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = MAX_W;
		end else begin
			w_eff = WW'(frame_width_q);
		end
	end

	assign h_eff = (frame_height_q == '0) ? FH_W'(1) : frame_height_q;
	assign h_ext = OROW_W'(h_eff);

	// ---------------------------------------------------------------
	// pipeline flow control
	// ---------------------------------------------------------------
	logic s1_v, s2_v, s3_v, out_v_q;
	logic out_free, s3_free, s2_free, s1_go;
	logic accept, enter, ent;

	assign out_free = !out_v_q || !out_stall;
	assign s3_free  = !s3_v || out_free;
	assign s2_free  = !s2_v || s3_free;
	assign s1_go    = s1_v && s2_free;
	assign in_stall = s1_v && !s2_free;
	assign accept   = in_valid && !in_stall;
	assign ent      = accept && enter;

	// ---------------------------------------------------------------
	// position counters, decided at the input beat
	// ---------------------------------------------------------------
	logic [CW-1:0]     in_col_q, out_col_q, in_col_d, out_col_d, addr_d;
	logic [ROW_W-1:0]  in_row_q, in_row_d;
	logic [OROW_W-1:0] out_row_q, out_row_d;
	logic [WW-1:0]     col_inc, ocol_inc;
	logic [OROW_W:0]   orow_inc;
	stage_ctl_t        ctl_d;

	assign orow_inc = (OROW_W + 1)'(out_row_q) + 1'b1;

	always_comb begin
		in_col_d  = in_col_q;
		in_row_d  = in_row_q;
		out_col_d = out_col_q;
		out_row_d = out_row_q;
		enter     = 1'b0;
		ctl_d     = '0;
		ctl_d.mode = MODE_PASS;
		addr_d    = in_col_q;
		col_inc   = '0;
		ocol_inc  = '0;

		if (in_data.operation == OP_DRAIN) begin
			// only once the whole frame is in and results remain
			if (in_row_q >= h_eff && out_row_q < h_ext) begin
				enter     = 1'b1;
				ctl_d.emit = 1'b1;
				addr_d    = out_col_q;
				// last row of results lives only in the memory
				if (orow_inc >= (OROW_W + 1)'(h_eff)) begin
					ctl_d.mode = MODE_MEM;
				end
			end
		end else begin
			if (in_row_q < h_eff || out_row_q >= h_ext) begin
				if (in_row_q >= h_eff) begin
					// previous frame done: this pixel opens a new one
					in_col_d  = '0;
					in_row_d  = '0;
					out_col_d = '0;
					out_row_d = '0;
				end
				enter       = 1'b1;
				ctl_d.pixel = 1'b1;
				addr_d      = in_col_d;
				if (in_row_d != '0 && in_col_d != '0) begin
					ctl_d.emit = 1'b1;
					if (in_row_d > ROW_W'(1) && in_col_d > CW'(1)) begin
						ctl_d.mode = MODE_SHARP;
					end
				end else if (in_row_d > ROW_W'(1)) begin
					ctl_d.emit = 1'b1;
				end
				col_inc = WW'(in_col_d) + 1'b1;
				if (col_inc >= w_eff) begin
					in_col_d = '0;
					in_row_d = in_row_d + 1'b1;
				end else begin
					in_col_d = col_inc[CW-1:0];
				end
			end
		end

		if (ctl_d.emit) begin
			ocol_inc = WW'(out_col_d) + 1'b1;
			if (ocol_inc >= w_eff) begin
				out_col_d = '0;
				out_row_d = out_row_d + 1'b1;
			end else begin
				out_col_d = ocol_inc[CW-1:0];
			end
			ctl_d.last = out_row_d >= h_ext;
			if (ctl_d.last && in_row_d >= h_eff) begin
				in_col_d  = '0;
				in_row_d  = '0;
				out_col_d = '0;
				out_row_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (accept) begin
			in_col_q  <= in_col_d;
			in_row_q  <= in_row_d;
			out_col_q <= out_col_d;
			out_row_q <= out_row_d;
		end
	end

	// ---------------------------------------------------------------
	// stage 1: row memory read data, write-back, window shift
	// ---------------------------------------------------------------
	// word = {row two above, row above}
	logic [2*PX_W-1:0] row_mem_q [MAX_WIDTH];
	logic [2*PX_W-1:0] rd_s1, fwd_data_s1, wr_data;
	logic              fwd_hit_s1, wr_en;
	stage_ctl_t        ctl_s1;
	logic [CW-1:0]     addr_s1;
	logic [PX_W-1:0]   pix_s1, above_eff, two_eff;

	assign wr_en     = s1_go && ctl_s1.pixel;
	assign above_eff = fwd_hit_s1 ? fwd_data_s1[PX_W-1:0] : rd_s1[PX_W-1:0];
	assign two_eff   = fwd_hit_s1 ? fwd_data_s1[2*PX_W-1:PX_W] : rd_s1[2*PX_W-1:PX_W];
	assign wr_data   = {above_eff, pix_s1};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			row_mem_q[addr_s1] <= wr_data;
		end
		if (ent) begin
			rd_s1 <= row_mem_q[addr_d];
		end
	end

	always_ff @(posedge clk) begin
		if (ent) begin
			ctl_s1      <= ctl_d;
			addr_s1     <= addr_d;
			pix_s1      <= {in_data.red_in, in_data.green_in, in_data.blue_in};
			// read raced the write-back of the beat ahead
			fwd_hit_s1  <= wr_en && (addr_s1 == addr_d);
			fwd_data_s1 <= wr_data;
		end
	end

	logic [PX_W-1:0] window_q [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
			for (int k = 0; k < 9; k++) begin
				window_q[k] <= '0;
			end
		end else begin
			if (!in_stall) begin
				s1_v <= ent;
			end
			if (wr_en) begin
				window_q[0] <= window_q[1];
				window_q[1] <= window_q[2];
				window_q[2] <= two_eff;
				window_q[3] <= window_q[4];
				window_q[4] <= window_q[5];
				window_q[5] <= above_eff;
				window_q[6] <= window_q[7];
				window_q[7] <= window_q[8];
				window_q[8] <= pix_s1;
			end
		end
	end

	// ---------------------------------------------------------------
	// stage 2: channel sums over the window
	// ---------------------------------------------------------------
	// the window holds this beat's state until the next beat leaves stage 1
	logic [PX_W-1:0]  px_s2;
	logic             sharp_s2, last_s2;
	logic [SUM_W-1:0] sum_d [3];

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			sum_d[ch] = '0;
			for (int k = 0; k < 9; k++) begin
				sum_d[ch] = sum_d[ch] + SUM_W'(window_q[k][ch*CH_W +: CH_W]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v <= 1'b0;
		end else if (s2_free) begin
			s2_v <= s1_v && ctl_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			px_s2    <= (ctl_s1.mode == MODE_MEM) ? above_eff : window_q[5];
			sharp_s2 <= ctl_s1.mode == MODE_SHARP;
			last_s2  <= ctl_s1.last;
		end
	end

	// ---------------------------------------------------------------
	// stage 3: mean, absolute detail, clip
	// ---------------------------------------------------------------
	function automatic logic [CH_W-1:0] sharpen_ch(input logic [CH_W-1:0]  center,
	                                               input logic [SUM_W-1:0] sum);
		logic [PROD_W-1:0] prod;
		logic [CH_W-1:0]   mean;
		logic [CH_W-1:0]   diff;
		logic [CH_W:0]     total;
		prod  = PROD_W'(sum) * PROD_W'(MEAN_RECIP);
		mean  = prod[MEAN_SHIFT +: CH_W];
		diff  = (center > mean) ? center - mean : mean - center;
		total = {1'b0, center} + {1'b0, diff};
		return total[CH_W] ? '1 : total[CH_W-1:0];
	endfunction

	logic [PX_W-1:0]  px_s3, res_d;
	logic [SUM_W-1:0] sum_s3 [3];
	logic             sharp_s3, last_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_v <= 1'b0;
		end else if (s3_free) begin
			s3_v <= s2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_v && s3_free) begin
			px_s3    <= px_s2;
			sum_s3   <= sum_d;
			sharp_s3 <= sharp_s2;
			last_s3  <= last_s2;
		end
	end

	always_comb begin
		res_d = px_s3;
		if (sharp_s3) begin
			for (int ch = 0; ch < 3; ch++) begin
				res_d[ch*CH_W +: CH_W] = sharpen_ch(px_s3[ch*CH_W +: CH_W], sum_s3[ch]);
			end
		end
	end

	// ---------------------------------------------------------------
	// output register
	// ---------------------------------------------------------------
	out_beat_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= s3_v;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_v && out_free) begin
			out_q.red_out    <= res_d[3*CH_W-1:2*CH_W];
			out_q.green_out  <= res_d[2*CH_W-1:CH_W];
			out_q.blue_out   <= res_d[CH_W-1:0];
			out_q.frame_last <= last_s3;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

`ifndef ASSERT_OFF
	// input back-pressure only ever comes from a blocked output beat
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a blocked output beat");

	// column counters always address inside the row memory
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(in_col_q) < 32'(MAX_WIDTH)) && (32'(out_col_q) < 32'(MAX_WIDTH)))
		else $error("column counter beyond row memory");

	// results read straight from memory belong to drain beats, which never write
	a_mem_drain_only: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v && ctl_s1.mode == MODE_MEM |-> !ctl_s1.pixel)
		else $error("memory-sourced result on a pixel beat");
`endif

endmodule
